// ===== design/rsg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ratchet step gate timer package
// Shared widths, register indexes, sequencer states, types and a helper function.
// ----------------------------------------------------------------------------
package rsg_pkg;

   localparam int TICK_W      = 26;
   localparam int TEMPO_W     = 17;
   localparam int STEP_LEN_W  = 18;
   localparam int Q16_W       = 17;
   localparam int Q16_FRAC    = 16;
   localparam int RETRIG_W    = 7;
   localparam int DEN_W       = 24;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 18;
   localparam int BUTTON_N    = 6;
   localparam int TEMPO_SCALE = 100;
   localparam int SECONDS_PER_MINUTE = 60;

   localparam logic [TICK_W-1:0]   STEP_MAX     = {TICK_W{1'b1}};
   localparam logic [Q16_W-1:0]    FULL_Q16     = 17'h10000;
   localparam logic [TEMPO_W-1:0]  TEMPO_MIN    = 17'd100;
   localparam logic [RETRIG_W-1:0] RETRIG_MAX   = 7'd64;
   localparam logic [13:0]         GATE_HIGH_MV = 14'd10000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEMPO,
      CSR_STEP_LEN,
      CSR_GATE_LEN,
      CSR_RETRIG_COUNT,
      CSR_RETRIG_DIST,
      CSR_RETRIG_OFFSET,
      CSR_STEP_PROB,
      CSR_ALT_PROB
   } rsg_csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NUM,
      ST_SCHK,
      ST_SDIV,
      ST_TICK,
      ST_MUL,
      ST_RCHK,
      ST_RDIV,
      ST_DONE
   } rsg_state_type;

   typedef enum logic [1:0] {
      FRAC_GATE,
      FRAC_DIST,
      FRAC_OFFSET
   } rsg_frac_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rsg_div_sts_type;

   function automatic logic [Q16_W-1:0] clamp_q16(input logic [Q16_W-1:0] v);
      return (v > FULL_Q16) ? FULL_Q16 : v;
   endfunction

endpackage

// ===== design/rsg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ratchet step gate timer channels
// Valid/ready channels for the per-tick request and the per-tick response.
// ----------------------------------------------------------------------------
interface rsg_req_if;
   logic               valid;
   logic               ready;
   logic               start_button;
   logic               activate_gate;
   logic               inhibit_gate;
   logic               cv_stack_button;
   logic               gate_stack_button;
   logic               mute_button;
   logic signed [14:0] gate_bridge_in;
   logic signed [14:0] cv_bridge_in;
   logic signed [15:0] cv_control_in;
   logic        [15:0] random_play;
   logic        [15:0] random_alt;

   modport source (
      output valid, start_button, activate_gate, inhibit_gate, cv_stack_button,
      output gate_stack_button, mute_button, gate_bridge_in, cv_bridge_in,
      output cv_control_in, random_play, random_alt,
      input  ready
   );

   modport sink (
      input  valid, start_button, activate_gate, inhibit_gate, cv_stack_button,
      input  gate_stack_button, mute_button, gate_bridge_in, cv_bridge_in,
      input  cv_control_in, random_play, random_alt,
      output ready
   );
endinterface

interface rsg_rsp_if;
   logic               valid;
   logic               ready;
   logic               end_pulse;
   logic               alt_end_pulse;
   logic        [13:0] gate_out_mv;
   logic signed [14:0] cv_out_mv;
   logic               step_armed;

   modport source (
      output valid, end_pulse, alt_end_pulse, gate_out_mv, cv_out_mv, step_armed,
      input  ready
   );

   modport sink (
      input  valid, end_pulse, alt_end_pulse, gate_out_mv, cv_out_mv, step_armed,
      output ready
   );
endinterface

// ===== design/rsg_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ratchet step gate timer divider
// Restoring divider giving one quotient bit per cycle from a shifted divisor.
// ----------------------------------------------------------------------------
module rsg_div import rsg_pkg::*; #(
   parameter int DVD_W = 42,
   parameter int DSR_W = 26,
   parameter int QUO_W = 26
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output rsg_div_sts_type  sts,
   output logic [QUO_W-1:0] quotient,
   output logic [DVD_W-1:0] remainder
);

   localparam int SH_W  = DSR_W + QUO_W - 1;
   localparam int CMP_W = (DVD_W > SH_W) ? DVD_W : SH_W;
   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [DVD_W-1:0] rem_ff;
   logic [SH_W-1:0]  dsh_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             done_ff;
   logic             ge_w;
   logic [CMP_W-1:0] sub_w;

   assign ge_w  = CMP_W'(rem_ff) >= CMP_W'(dsh_ff);
   assign sub_w = CMP_W'(rem_ff) - CMP_W'(dsh_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CNT_W'(QUO_W);
         end else if (cnt_ff != '0) begin
            cnt_ff  <= cnt_ff - CNT_W'(1);
            done_ff <= (cnt_ff == CNT_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend;
         dsh_ff <= SH_W'(divisor) << (QUO_W - 1);
         quo_ff <= '0;
      end else if (cnt_ff != '0) begin
         if (ge_w) begin
            rem_ff <= sub_w[DVD_W-1:0];
         end
         quo_ff <= {quo_ff[QUO_W-2:0], ge_w};
         dsh_ff <= dsh_ff >> 1;
      end
   end

   assign sts.busy  = (cnt_ff != '0);
   assign sts.done  = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== design/ratchet_step_gate_timer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ratchet step gate timer core
// Per-sample step timer with ratcheted gates, probability and bridge pass-through.
// ----------------------------------------------------------------------------
// One request transaction is one sample tick and yields exactly one response
// transaction. The block takes one tick at a time. A tick with no step armed,
// or the tick that ends a step, goes straight to its response. A tick inside a
// running step first uses the shared multiplier for gate length, spacing and
// offset, then, once past the offset, the bit-serial divider that finds the
// current gate within the burst. The tick that arms a step first works out the
// step length in ticks on the multiplier and, unless it saturates, that same
// divider. The block waits further only while a response waits to be taken.
module ratchet_step_gate_timer_core import rsg_pkg::*; #(
   parameter int SAMPLE_RATE = 48000
) (
   input  logic                  clock,
   input  logic                  reset,
   rsg_req_if.sink               req_ch,
   rsg_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SR60    = SAMPLE_RATE * SECONDS_PER_MINUTE;
   localparam int SR60_W  = $clog2(SR60 + 1);
   localparam int NUM_W   = STEP_LEN_W + SR60_W;
   localparam int MUL_A_W = TICK_W;
   localparam int MUL_B_W = (SR60_W > Q16_W) ? SR60_W : Q16_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int DVD_W   = (NUM_W > TICK_W) ? NUM_W : TICK_W;
   localparam int OVF_W   = (NUM_W > DEN_W + TICK_W) ? NUM_W : DEN_W + TICK_W;

   // Configuration registers
   logic [TEMPO_W-1:0]    tempo_ff;
   logic [STEP_LEN_W-1:0] step_len_ff;
   logic [Q16_W-1:0]      gate_len_ff;
   logic [RETRIG_W-1:0]   retrig_count_ff;
   logic [Q16_W-1:0]      retrig_dist_ff;
   logic [Q16_W-1:0]      retrig_offset_ff;
   logic [Q16_W-1:0]      step_prob_ff;
   logic [Q16_W-1:0]      alt_prob_ff;

   // Control state
   rsg_state_type         state_ff;
   rsg_state_type         state_in;
   rsg_frac_type          mul_sel_ff;
   logic [BUTTON_N-1:0]   prev_lv_ff;
   logic                  armed_ff;
   logic                  play_ff;
   logic                  alt_ff;
   logic                  cv_stack_ff;
   logic                  gate_stack_ff;
   logic                  mute_ff;
   logic [TICK_W-1:0]     ticks_left_ff;
   logic [TICK_W-1:0]     elapsed_ff;
   logic [TICK_W-1:0]     step_ticks_ff;
   logic                  before_ff;
   logic                  rsp_valid_ff;

   // Working registers
   logic signed [14:0]    in_gb_ff;
   logic signed [14:0]    in_cvb_ff;
   logic signed [15:0]    in_cvc_ff;
   logic [NUM_W-1:0]      num_ff;
   logic [DEN_W-1:0]      den_ff;
   logic [TICK_W-1:0]     gt_ff;
   logic [TICK_W-1:0]     dist_ff;
   logic [TICK_W-1:0]     off_ff;
   logic [TICK_W-1:0]     m_ff;
   logic [TICK_W-1:0]     r_ff;
   logic                  rsp_end_ff;
   logic                  rsp_alt_ff;
   logic [13:0]           rsp_gate_ff;
   logic signed [14:0]    rsp_cv_ff;
   logic                  rsp_armed_ff;

   // Combinational signals
   logic [BUTTON_N-1:0]   lv_w;
   logic [BUTTON_N-1:0]   rise_w;
   logic                  req_acc_w;
   logic                  arm_now_w;
   logic                  armed_next_w;
   logic                  play_w;
   logic                  alt_w;
   logic [TEMPO_W-1:0]    tempo_c_w;
   logic [Q16_W-1:0]      frac_q_w;
   logic [MUL_A_W-1:0]    mul_a_w;
   logic [MUL_B_W-1:0]    mul_b_w;
   logic [PROD_W-1:0]     mul_p_w;
   logic [TICK_W-1:0]     frac_w;
   logic                  ovf_w;
   logic                  before_w;
   logic [TICK_W-1:0]     diff_w;
   logic [DVD_W-1:0]      div_dvd_w;
   logic [TICK_W-1:0]     div_dsr_w;
   logic [TICK_W-1:0]     div_quo_w;
   logic [DVD_W-1:0]      div_rem_w;
   rsg_div_sts_type       div_sts;
   logic                  div_start_w;
   logic                  req_ready_w;
   logic                  rsp_load_w;
   logic                  out_free_w;
   logic [RETRIG_W-1:0]   ntr_w;
   logic                  gate_on_w;
   logic [13:0]           gb_clamp_w;
   logic signed [16:0]    cv_sum_w;
   logic signed [14:0]    cv_clamp_w;
   logic                  end_kind_w;
   logic                  res_end_w;
   logic                  res_alt_w;
   logic [13:0]           res_gate_w;
   logic signed [14:0]    res_cv_w;
   logic                  res_armed_w;

   assign lv_w = {req_ch.mute_button, req_ch.gate_stack_button, req_ch.cv_stack_button,
                  req_ch.inhibit_gate, req_ch.activate_gate, req_ch.start_button};
   assign rise_w       = lv_w & ~prev_lv_ff;
   assign req_acc_w    = req_ch.valid && req_ch.ready;
   assign arm_now_w    = (|rise_w[1:0]) && !armed_ff;
   assign armed_next_w = (armed_ff || (|rise_w[1:0])) && !rise_w[2];
   assign play_w = ({2'b00, req_ch.random_play} + {1'b0, step_prob_ff}) >= {1'b0, FULL_Q16};
   assign alt_w  = ({2'b00, req_ch.random_alt} + {1'b0, alt_prob_ff}) > {1'b0, FULL_Q16};

   assign tempo_c_w = (tempo_ff < TEMPO_MIN) ? TEMPO_MIN : tempo_ff;

   always_comb begin
      case (mul_sel_ff)
         FRAC_GATE:   frac_q_w = clamp_q16(gate_len_ff);
         FRAC_DIST:   frac_q_w = clamp_q16(retrig_dist_ff);
         FRAC_OFFSET: frac_q_w = clamp_q16(retrig_offset_ff);
         default:     frac_q_w = '0;
      endcase
   end

   // Shared multiplier: step numerator on arming, step fractions on each tick of a running step.
   assign mul_a_w = (state_ff == ST_NUM) ? MUL_A_W'(step_len_ff) : step_ticks_ff;
   assign mul_b_w = (state_ff == ST_NUM) ? MUL_B_W'(SR60) : MUL_B_W'(frac_q_w);
   assign mul_p_w = PROD_W'(mul_a_w) * PROD_W'(mul_b_w);
   assign frac_w  = mul_p_w[TICK_W+Q16_FRAC-1:Q16_FRAC];

   assign ovf_w    = OVF_W'(num_ff) >= OVF_W'({den_ff, {TICK_W{1'b0}}});
   assign before_w = elapsed_ff < off_ff;
   assign diff_w   = elapsed_ff - off_ff;

   assign div_dvd_w = (state_ff == ST_SCHK) ? DVD_W'(num_ff) : DVD_W'(diff_w);
   assign div_dsr_w = (state_ff == ST_SCHK) ? TICK_W'(den_ff) : dist_ff;

   rsg_div #(
      .DVD_W (DVD_W),
      .DSR_W (TICK_W),
      .QUO_W (TICK_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_w),
      .dividend  (div_dvd_w),
      .divisor   (div_dsr_w),
      .sts       (div_sts),
      .quotient  (div_quo_w),
      .remainder (div_rem_w)
   );

   assign out_free_w = !rsp_valid_ff || rsp_ch.ready;

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc_w) begin
               state_in = (arm_now_w && !rise_w[2]) ? ST_NUM : ST_TICK;
            end
         end
         ST_NUM:  state_in = ST_SCHK;
         ST_SCHK: state_in = ovf_w ? ST_TICK : ST_SDIV;
         ST_SDIV: begin
            if (div_sts.done) begin
               state_in = ST_TICK;
            end
         end
         ST_TICK: begin
            state_in = (armed_ff && ticks_left_ff != '0) ? ST_MUL : ST_DONE;
         end
         ST_MUL: begin
            if (mul_sel_ff == FRAC_OFFSET) begin
               state_in = ST_RCHK;
            end
         end
         ST_RCHK: state_in = div_start_w ? ST_RDIV : ST_DONE;
         ST_RDIV: begin
            if (div_sts.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free_w) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready_w = 1'b0;
      div_start_w = 1'b0;
      rsp_load_w  = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready_w = 1'b1;
         ST_SCHK: div_start_w = !ovf_w;
         ST_RCHK: div_start_w = !before_w && (dist_ff != '0);
         ST_DONE: rsp_load_w  = out_free_w;
         default: begin
            req_ready_w = 1'b0;
         end
      endcase
   end

   assign req_ch.ready = req_ready_w;

   // Result of the tick
   assign ntr_w = (retrig_count_ff > RETRIG_MAX) ? RETRIG_MAX : retrig_count_ff;
   assign gate_on_w = play_ff && !before_ff && (m_ff < TICK_W'(ntr_w)) && (r_ff <= gt_ff);

   always_comb begin
      if (in_gb_ff <= 15'sd0) begin
         gb_clamp_w = '0;
      end else if (in_gb_ff > 15'sd10000) begin
         gb_clamp_w = GATE_HIGH_MV;
      end else begin
         gb_clamp_w = in_gb_ff[13:0];
      end
   end

   assign cv_sum_w = 17'(in_cvc_ff) + (cv_stack_ff ? 17'(in_cvb_ff) : 17'sd0);

   always_comb begin
      if (cv_sum_w < 17'sd0) begin
         cv_clamp_w = '0;
      end else if (cv_sum_w > 17'sd10000) begin
         cv_clamp_w = 15'sd10000;
      end else begin
         cv_clamp_w = cv_sum_w[14:0];
      end
   end

   assign end_kind_w = armed_ff && (ticks_left_ff == '0);

   always_comb begin
      res_end_w   = 1'b0;
      res_alt_w   = 1'b0;
      res_gate_w  = gb_clamp_w;
      res_cv_w    = in_cvb_ff;
      res_armed_w = 1'b0;
      if (end_kind_w) begin
         res_end_w  = !alt_ff;
         res_alt_w  = alt_ff;
         res_gate_w = '0;
         res_cv_w   = '0;
      end else if (armed_ff) begin
         res_armed_w = 1'b1;
         res_cv_w    = cv_clamp_w;
         if (gate_on_w) begin
            res_gate_w = mute_ff ? 14'd0 : GATE_HIGH_MV;
         end else begin
            res_gate_w = (gate_stack_ff && !mute_ff) ? gb_clamp_w : 14'd0;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         mul_sel_ff       <= FRAC_GATE;
         tempo_ff         <= 17'd11700;
         step_len_ff      <= 18'd10000;
         gate_len_ff      <= '0;
         retrig_count_ff  <= 7'd1;
         retrig_dist_ff   <= FULL_Q16;
         retrig_offset_ff <= '0;
         step_prob_ff     <= FULL_Q16;
         alt_prob_ff      <= '0;
         prev_lv_ff       <= '1;
         armed_ff         <= 1'b0;
         play_ff          <= 1'b0;
         alt_ff           <= 1'b0;
         cv_stack_ff      <= 1'b0;
         gate_stack_ff    <= 1'b0;
         mute_ff          <= 1'b0;
         ticks_left_ff    <= '0;
         elapsed_ff       <= '0;
         step_ticks_ff    <= '0;
         before_ff        <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            case (rsg_csr_index_type'(csr_index))
               CSR_TEMPO:         tempo_ff         <= csr_wdata[TEMPO_W-1:0];
               CSR_STEP_LEN:      step_len_ff      <= csr_wdata[STEP_LEN_W-1:0];
               CSR_GATE_LEN:      gate_len_ff      <= csr_wdata[Q16_W-1:0];
               CSR_RETRIG_COUNT:  retrig_count_ff  <= csr_wdata[RETRIG_W-1:0];
               CSR_RETRIG_DIST:   retrig_dist_ff   <= csr_wdata[Q16_W-1:0];
               CSR_RETRIG_OFFSET: retrig_offset_ff <= csr_wdata[Q16_W-1:0];
               CSR_STEP_PROB:     step_prob_ff     <= csr_wdata[Q16_W-1:0];
               CSR_ALT_PROB:      alt_prob_ff      <= csr_wdata[Q16_W-1:0];
               default: begin
                  tempo_ff <= tempo_ff;
               end
            endcase
         end

         if (req_acc_w) begin
            prev_lv_ff <= lv_w;
            armed_ff   <= armed_next_w;
            if (arm_now_w) begin
               elapsed_ff <= '0;
               play_ff    <= play_w;
               alt_ff     <= alt_w;
            end
            if (rise_w[3]) begin
               cv_stack_ff <= !cv_stack_ff;
            end
            if (rise_w[4]) begin
               gate_stack_ff <= !gate_stack_ff;
            end
            if (rise_w[5]) begin
               mute_ff <= !mute_ff;
            end
         end

         if (state_ff == ST_SCHK && ovf_w) begin
            step_ticks_ff <= STEP_MAX;
            ticks_left_ff <= STEP_MAX;
         end
         if (state_ff == ST_SDIV && div_sts.done) begin
            step_ticks_ff <= div_quo_w;
            ticks_left_ff <= div_quo_w;
         end

         if (state_ff == ST_TICK) begin
            mul_sel_ff <= FRAC_GATE;
         end
         if (state_ff == ST_MUL) begin
            case (mul_sel_ff)
               FRAC_GATE:   mul_sel_ff <= FRAC_DIST;
               FRAC_DIST:   mul_sel_ff <= FRAC_OFFSET;
               default:     mul_sel_ff <= FRAC_GATE;
            endcase
         end
         if (state_ff == ST_RCHK) begin
            before_ff <= before_w;
         end

         if (rsp_load_w) begin
            rsp_valid_ff <= 1'b1;
            if (end_kind_w) begin
               armed_ff <= 1'b0;
            end else if (armed_ff) begin
               ticks_left_ff <= ticks_left_ff - TICK_W'(1);
               elapsed_ff    <= elapsed_ff + TICK_W'(1);
            end
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      if (req_acc_w) begin
         in_gb_ff  <= req_ch.gate_bridge_in;
         in_cvb_ff <= req_ch.cv_bridge_in;
         in_cvc_ff <= req_ch.cv_control_in;
      end
      if (state_ff == ST_NUM) begin
         num_ff <= mul_p_w[NUM_W-1:0];
         den_ff <= DEN_W'(tempo_c_w) * DEN_W'(TEMPO_SCALE);
      end
      if (state_ff == ST_MUL) begin
         case (mul_sel_ff)
            FRAC_GATE:   gt_ff   <= frac_w;
            FRAC_DIST:   dist_ff <= frac_w;
            FRAC_OFFSET: off_ff  <= frac_w;
            default: begin
               gt_ff <= gt_ff;
            end
         endcase
      end
      if (state_ff == ST_RCHK) begin
         m_ff <= '0;
         r_ff <= diff_w;
      end
      if (state_ff == ST_RDIV && div_sts.done) begin
         m_ff <= div_quo_w;
         r_ff <= div_rem_w[TICK_W-1:0];
      end
      if (rsp_load_w) begin
         rsp_end_ff   <= res_end_w;
         rsp_alt_ff   <= res_alt_w;
         rsp_gate_ff  <= res_gate_w;
         rsp_cv_ff    <= res_cv_w;
         rsp_armed_ff <= res_armed_w;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.end_pulse     = rsp_end_ff;
   assign rsp_ch.alt_end_pulse = rsp_alt_ff;
   assign rsp_ch.gate_out_mv   = rsp_gate_ff;
   assign rsp_ch.cv_out_mv     = rsp_cv_ff;
   assign rsp_ch.step_armed    = rsp_armed_ff;

   // While a step runs, the remaining and elapsed tick counts add up to its length.
   a_tick_balance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && armed_ff) |->
         ({1'b0, ticks_left_ff} + {1'b0, elapsed_ff}) == {1'b0, step_ticks_ff})
      else $error("tick counters out of balance with the step length");

   // The divider is only started when it is free.
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start_w |-> !div_sts.busy)
      else $error("divider started while busy");

   // A divider result only appears while the sequencer waits for it.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == ST_SDIV || state_ff == ST_RDIV))
      else $error("divider result not awaited");

   // A response carrying an end pulse never reports the step as still armed.
   a_end_disarms: assert property (@(posedge clock) disable iff (reset)
      (rsp_load_w && (res_end_w || res_alt_w)) |=> !armed_ff && !rsp_ch.step_armed)
      else $error("end pulse issued while the step stays armed");

endmodule

// ===== tb/tb_ratchet_step_gate_timer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ratchet step gate timer core testbench
// Sends sample ticks through the request channel and predicts every response
// with an independent model of the step timer. A short directed run covers
// pass-through, ratchets, stacking, mute, zero length steps, saturation and
// inhibit. Random runs under varied settings, idling and back-pressure follow.
// ----------------------------------------------------------------------------
module tb_ratchet_step_gate_timer_core;
   import rsg_pkg::*;

   localparam int TICK_RATE = 48000;
   localparam int BTN_START = 0;
   localparam int BTN_ACTIVATE = 1;
   localparam int BTN_INHIBIT = 2;
   localparam int BTN_CV = 3;
   localparam int BTN_GATE = 4;
   localparam int BTN_MUTE = 5;
   localparam int MODE_CV = 0;
   localparam int MODE_GATE = 1;
   localparam int MODE_MUTE = 2;

   typedef struct packed {
      logic [BUTTON_N-1:0] buttons;
      logic signed [14:0]  gate_br;
      logic signed [14:0]  cv_br;
      logic signed [15:0]  cv_ctl;
      logic [15:0]         rnd_play;
      logic [15:0]         rnd_alt;
   } tick_type;

   typedef struct packed {
      logic               end_pulse;
      logic               alt_pulse;
      logic [13:0]        gate_mv;
      logic signed [14:0] cv_mv;
      logic               armed;
   } reading_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rsg_req_if req_bus ();
   rsg_rsp_if rsp_bus ();

   ratchet_step_gate_timer_core #(.SAMPLE_RATE(TICK_RATE)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Register copies as the block holds them.
   logic [TEMPO_W-1:0]    cfg_tempo = 17'd11700;
   logic [STEP_LEN_W-1:0] cfg_step_len = 18'd10000;
   logic [Q16_W-1:0]      cfg_gate_len = '0;
   logic [RETRIG_W-1:0]   cfg_retrig = 7'd1;
   logic [Q16_W-1:0]      cfg_dist = 17'h10000;
   logic [Q16_W-1:0]      cfg_offset = '0;
   logic [Q16_W-1:0]      cfg_step_prob = 17'h10000;
   logic [Q16_W-1:0]      cfg_alt_prob = '0;

   // Timer state.
   logic [BUTTON_N-1:0] prev_lvl = '1;
   logic                armed = 1'b0;
   logic                play = 1'b0;
   logic                alt = 1'b0;
   logic [26:0]         ticks_left = '0;
   logic [TICK_W-1:0]   ticks_done = '0;
   logic [TICK_W-1:0]   step_ticks = '0;
   logic [2:0]          modes = '0;

   tick_type            tick_queue[$];
   reading_type         due_outputs[$];
   logic [BUTTON_N-1:0] btn_lvl = '1;
   int                  n_errors = 0;
   bit                  req_busy = 1'b0;
   bit                  req_hs = 1'b0;
   bit                  rsp_hs = 1'b0;
   bit                  idle_en = 1'b1;
   bit                  hold_req = 1'b0;
   int                  req_gap = 0;
   int                  rsp_gap = 0;
   int                  hold_left = 0;

   always #10 clock = ~clock;

   function automatic longint unsigned step_share(input logic [Q16_W-1:0] q);
      longint unsigned f;
      f = (q > FULL_Q16) ? FULL_Q16 : q;
      return (f * step_ticks) >> Q16_FRAC;
   endfunction

   task automatic apply_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] d);
      case (rsg_csr_index_type'(idx))
         CSR_TEMPO:         cfg_tempo = d[TEMPO_W-1:0];
         CSR_STEP_LEN:      cfg_step_len = d[STEP_LEN_W-1:0];
         CSR_GATE_LEN:      cfg_gate_len = d[Q16_W-1:0];
         CSR_RETRIG_COUNT:  cfg_retrig = d[RETRIG_W-1:0];
         CSR_RETRIG_DIST:   cfg_dist = d[Q16_W-1:0];
         CSR_RETRIG_OFFSET: cfg_offset = d[Q16_W-1:0];
         CSR_STEP_PROB:     cfg_step_prob = d[Q16_W-1:0];
         CSR_ALT_PROB:      cfg_alt_prob = d[Q16_W-1:0];
         default: ;
      endcase
   endtask

   task automatic advance_timer(input tick_type t, output reading_type r);
      logic [BUTTON_N-1:0] rise;
      bit                  was_armed;
      bit                  pulse;
      bit                  mute;
      int                  gb, cvb, cvc, gate, cv, s;
      int unsigned         sum;
      longint unsigned     tempo, len, cnt, gt, spacing, off, ntr, m, st;
      rise = t.buttons & ~prev_lvl;
      prev_lvl = t.buttons;
      was_armed = armed;
      pulse = 1'b0;
      gate = 0;
      cv = 0;
      gb = t.gate_br;
      cvb = t.cv_br;
      cvc = t.cv_ctl;
      if (rise[BTN_START] || rise[BTN_ACTIVATE]) armed = 1'b1;
      if (!was_armed && armed) begin
         tempo = (cfg_tempo < TEMPO_MIN) ? TEMPO_MIN : cfg_tempo;
         len = cfg_step_len;
         len = len * TICK_RATE * SECONDS_PER_MINUTE / (tempo * TEMPO_SCALE);
         step_ticks = (len > STEP_MAX) ? STEP_MAX : len[TICK_W-1:0];
         ticks_left = step_ticks;
         ticks_done = '0;
         sum = t.rnd_play + cfg_step_prob;
         play = (sum >= FULL_Q16);
         sum = t.rnd_alt + cfg_alt_prob;
         alt = (sum > FULL_Q16);
      end
      if (rise[BTN_CV]) modes[MODE_CV] = ~modes[MODE_CV];
      if (rise[BTN_GATE]) modes[MODE_GATE] = ~modes[MODE_GATE];
      if (rise[BTN_MUTE]) modes[MODE_MUTE] = ~modes[MODE_MUTE];
      if (rise[BTN_INHIBIT]) armed = 1'b0;
      if (armed) begin
         if (ticks_left == 0) begin
            armed = 1'b0;
            pulse = 1'b1;
         end else begin
            mute = modes[MODE_MUTE];
            cnt = ticks_done;
            gt = step_share(cfg_gate_len);
            spacing = step_share(cfg_dist);
            off = step_share(cfg_offset);
            ntr = (cfg_retrig > RETRIG_MAX) ? RETRIG_MAX : cfg_retrig;
            m = (spacing > 0 && cnt > off) ? (cnt - off) / spacing : 0;
            st = off + m * spacing;
            if (play && m < ntr && cnt >= st && cnt <= st + gt)
               gate = mute ? 0 : GATE_HIGH_MV;
            else if (modes[MODE_GATE] && !mute && gb > 0)
               gate = (gb > GATE_HIGH_MV) ? GATE_HIGH_MV : gb;
            s = cvc + (modes[MODE_CV] ? cvb : 0);
            cv = (s < 0) ? 0 : ((s > 10000) ? 10000 : s);
            ticks_left = ticks_left - 1'b1;
            ticks_done = ticks_done + 1'b1;
         end
      end else begin
         gate = (gb < 0) ? 0 : ((gb > GATE_HIGH_MV) ? GATE_HIGH_MV : gb);
         cv = cvb;
      end
      r.end_pulse = pulse && !alt;
      r.alt_pulse = pulse && alt;
      r.gate_mv = gate[13:0];
      r.cv_mv = cv[14:0];
      r.armed = armed;
   endtask

   task automatic check_reading(input reading_type got);
      reading_type want;
      if (due_outputs.size() == 0) begin
         $display("%0t: response with none expected", $time);
         n_errors++;
         return;
      end
      want = due_outputs.pop_front();
      if (got.end_pulse !== want.end_pulse) begin
         $display("%0t: end_pulse expected %0d, got %0d", $time, want.end_pulse,
                  got.end_pulse);
         n_errors++;
      end
      if (got.alt_pulse !== want.alt_pulse) begin
         $display("%0t: alt_end_pulse expected %0d, got %0d", $time, want.alt_pulse,
                  got.alt_pulse);
         n_errors++;
      end
      if (got.gate_mv !== want.gate_mv) begin
         $display("%0t: gate_out_mv expected %0d, got %0d", $time, want.gate_mv,
                  got.gate_mv);
         n_errors++;
      end
      if (got.cv_mv !== want.cv_mv) begin
         $display("%0t: cv_out_mv expected %0d, got %0d", $time, want.cv_mv, got.cv_mv);
         n_errors++;
      end
      if (got.armed !== want.armed) begin
         $display("%0t: step_armed expected %0d, got %0d", $time, want.armed, got.armed);
         n_errors++;
      end
   endtask

   // Checks responses, then predicts the request taken at the same edge.
   always @(posedge clock) begin
      reading_type got;
      reading_type want;
      if (!reset) begin
         if (csr_we) apply_reg(csr_index, csr_wdata);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.end_pulse = rsp_bus.end_pulse;
            got.alt_pulse = rsp_bus.alt_end_pulse;
            got.gate_mv = rsp_bus.gate_out_mv;
            got.cv_mv = rsp_bus.cv_out_mv;
            got.armed = rsp_bus.step_armed;
            check_reading(got);
            rsp_hs = 1'b1;
         end
         if (req_bus.valid && req_bus.ready) begin
            advance_timer({req_bus.mute_button, req_bus.gate_stack_button,
                           req_bus.cv_stack_button, req_bus.inhibit_gate,
                           req_bus.activate_gate, req_bus.start_button,
                           req_bus.gate_bridge_in, req_bus.cv_bridge_in,
                           req_bus.cv_control_in, req_bus.random_play,
                           req_bus.random_alt}, want);
            due_outputs.push_back(want);
            req_hs = 1'b1;
         end
      end
   end

   always @(negedge clock) begin
      tick_type t;
      if (req_hs) begin
         req_hs = 1'b0;
         req_busy = 1'b0;
         req_gap = idle_en ? $urandom_range(0, 7) : 0;
      end
      if (!reset && !req_busy) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (tick_queue.size() > 0) begin
            t = tick_queue.pop_front();
            req_bus.start_button <= t.buttons[BTN_START];
            req_bus.activate_gate <= t.buttons[BTN_ACTIVATE];
            req_bus.inhibit_gate <= t.buttons[BTN_INHIBIT];
            req_bus.cv_stack_button <= t.buttons[BTN_CV];
            req_bus.gate_stack_button <= t.buttons[BTN_GATE];
            req_bus.mute_button <= t.buttons[BTN_MUTE];
            req_bus.gate_bridge_in <= t.gate_br;
            req_bus.cv_bridge_in <= t.cv_br;
            req_bus.cv_control_in <= t.cv_ctl;
            req_bus.random_play <= t.rnd_play;
            req_bus.random_alt <= t.rnd_alt;
            req_busy = 1'b1;
         end
      end
      req_bus.valid <= req_busy;
   end

   always @(negedge clock) begin
      if (rsp_hs) begin
         rsp_hs = 1'b0;
         rsp_gap = idle_en ? $urandom_range(0, 7) : 0;
      end
      if (hold_req) begin
         hold_req = 1'b0;
         hold_left = 600;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic write_reg(input rsg_csr_index_type idx, input int unsigned value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic program_timer(input int unsigned tempo, len, gate, count, spacing,
                                input int unsigned offset, sprob, aprob);
      write_reg(CSR_TEMPO, tempo);
      write_reg(CSR_STEP_LEN, len);
      write_reg(CSR_GATE_LEN, gate);
      write_reg(CSR_RETRIG_COUNT, count);
      write_reg(CSR_RETRIG_DIST, spacing);
      write_reg(CSR_RETRIG_OFFSET, offset);
      write_reg(CSR_STEP_PROB, sprob);
      write_reg(CSR_ALT_PROB, aprob);
   endtask

   task automatic push_tick(input logic [BUTTON_N-1:0] lv, input int gb, cvb, cvc,
                            input int rp, ra);
      tick_type t;
      t.buttons = lv;
      t.gate_br = gb[14:0];
      t.cv_br = cvb[14:0];
      t.cv_ctl = cvc[15:0];
      t.rnd_play = rp[15:0];
      t.rnd_alt = ra[15:0];
      btn_lvl = lv;
      tick_queue.push_back(t);
   endtask

   // Mostly arm, run and end steps; now and then the levels are scrambled.
   task automatic push_random_tick();
      logic [BUTTON_N-1:0] lv;
      int                  gb, cvb, cvc;
      lv = btn_lvl;
      if ($urandom_range(0, 11) == 0) lv[BTN_START] = ~lv[BTN_START];
      if ($urandom_range(0, 11) == 0) lv[BTN_ACTIVATE] = ~lv[BTN_ACTIVATE];
      if ($urandom_range(0, 47) == 0) lv[BTN_INHIBIT] = ~lv[BTN_INHIBIT];
      if ($urandom_range(0, 29) == 0) lv[BTN_CV] = ~lv[BTN_CV];
      if ($urandom_range(0, 29) == 0) lv[BTN_GATE] = ~lv[BTN_GATE];
      if ($urandom_range(0, 29) == 0) lv[BTN_MUTE] = ~lv[BTN_MUTE];
      if ($urandom_range(0, 39) == 0) lv = BUTTON_N'($urandom);
      gb = ($urandom_range(0, 9) == 0) ? int'($urandom) : int'($urandom_range(0, 20000)) - 10000;
      cvb = ($urandom_range(0, 9) == 0) ? int'($urandom) : int'($urandom_range(0, 20000)) - 10000;
      cvc = ($urandom_range(0, 9) == 0) ? int'($urandom) : int'($urandom_range(0, 30000)) - 10000;
      push_tick(lv, gb, cvb, cvc, $urandom, $urandom);
   endtask

   function automatic int unsigned pick_q16();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return FULL_Q16;
         2: return $urandom_range(FULL_Q16 + 1, 131071);
         default: return $urandom_range(0, FULL_Q16);
      endcase
   endfunction

   function automatic int unsigned pick_retrig();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return RETRIG_MAX;
         2: return $urandom_range(RETRIG_MAX + 1, 127);
         default: return $urandom_range(1, 6);
      endcase
   endfunction

   task automatic settle();
      while (tick_queue.size() != 0 || req_busy || due_outputs.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      logic [BUTTON_N-1:0] lv;
      int unsigned         tempo, eff, len;
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.start_button = 1'b0;
      req_bus.activate_gate = 1'b0;
      req_bus.inhibit_gate = 1'b0;
      req_bus.cv_stack_button = 1'b0;
      req_bus.gate_stack_button = 1'b0;
      req_bus.mute_button = 1'b0;
      req_bus.gate_bridge_in = '0;
      req_bus.cv_bridge_in = '0;
      req_bus.cv_control_in = '0;
      req_bus.random_play = '0;
      req_bus.random_alt = '0;
      rsp_bus.ready = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A twelve tick step with three short ratchets, stacking and mute.
      program_timer(80099, 34, 16384, 3, 21845, 8192, FULL_Q16, 32768);
      push_tick('1, 10000, -10000, 0, 0, 0);
      push_tick('0, -10000, 10000, -10000, 0, 0);
      push_tick('0, 16383, -16384, -32768, 65535, 65535);
      lv = '0;
      lv[BTN_START] = 1'b1;
      push_tick(lv, -16384, 16383, 32767, 0, 0);
      for (int i = 0; i < 12; i++) begin
         lv[BTN_ACTIVATE] = (i >= 1);
         lv[BTN_CV] = (i >= 2);
         lv[BTN_GATE] = (i >= 3);
         lv[BTN_MUTE] = (i == 6 || i == 9);
         push_tick(lv, (i % 3 == 0) ? 12000 : ((i % 3 == 1) ? 3000 : -5),
                   7000 - 1500 * i, -2000 + 1000 * i, $urandom, $urandom);
      end
      push_tick('0, 500, 500, 500, 0, 0);
      lv = '0;
      lv[BTN_START] = 1'b1;
      lv[BTN_INHIBIT] = 1'b1;
      push_tick(lv, 2000, -3000, 4000, 0, 0);
      settle();

      // Zero length steps end with their pulse in the arming tick.
      program_timer(11700, 0, 0, 1, FULL_Q16, 0, 0, FULL_Q16);
      lv = '0;
      lv[BTN_START] = 1'b1;
      push_tick(lv, 100, 100, 100, 65535, 1);
      lv = '0;
      lv[BTN_ACTIVATE] = 1'b1;
      push_tick(lv, 100, 100, 100, 0, 0);
      settle();

      // Tempo below the minimum, saturated length and over-range fractions.
      program_timer(0, 262143, 131071, 127, 131071, 131071, 131071, 0);
      lv = '0;
      lv[BTN_START] = 1'b1;
      push_tick(lv, 9000, 9000, 9000, 65535, 65535);
      push_tick(lv, -9000, -9000, -9000, 0, 0);
      push_tick(lv, 0, 0, 0, 0, 0);
      lv[BTN_INHIBIT] = 1'b1;
      push_tick(lv, 1, -1, 1, 0, 0);
      settle();

      for (int phase = 0; phase < 8; phase++) begin
         idle_en = (phase != 1);
         case (phase)
            0: tempo = 80099;
            2: tempo = 100;
            4: tempo = $urandom_range(0, 99);
            default: tempo = $urandom_range(20000, 80099);
         endcase
         eff = (tempo < TEMPO_MIN) ? TEMPO_MIN : tempo;
         len = (phase == 6) ? 160050 : $urandom_range(0, eff * 60 / 28800 + 1);
         program_timer(tempo, len, pick_q16(), pick_retrig(), pick_q16(), pick_q16(),
                       pick_q16(), pick_q16());
         for (int i = 0; i < 166; i++) begin
            if (phase == 5 && i == 83) settle();
            push_random_tick();
         end
         if (phase == 3) hold_req = 1'b1;
         settle();
      end

      repeat (40) @(posedge clock);
      if (due_outputs.size() != 0)
         $display("%0t: %0d responses never arrived", $time, due_outputs.size());
      if (n_errors == 0 && due_outputs.size() == 0) begin
         $display("tb_ratchet_step_gate_timer_core passed");
      end else begin
         $display("tb_ratchet_step_gate_timer_core failed");
      end
      $finish;
   end

   initial begin
      #(15_000_000);
      $display("%0t: timeout", $time);
      $display("tb_ratchet_step_gate_timer_core failed");
      $finish;
   end

endmodule
